### hw/rtl/lbsh_pkg.sv
// lbsh_pkg: shared widths, defaults and codes for the lod band select block
// no dependencies; imported by lbsh_sq_unit and lod_band_select_hysteresis

package lbsh_pkg;

  localparam int unsigned NumObjectsDef = 256;
  localparam int unsigned MaxBandsDef   = 8;

  localparam int unsigned COORD_W = 20;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned DIST_W  = 43;
  localparam int unsigned HYST_W  = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned OBJ_W   = 8;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned BAND_OUT_W = 4;

  localparam int unsigned S_DATA_W = 120;
  localparam int unsigned M_DATA_W = 64;

  localparam logic [HYST_W-1:0] HystResetVal = HYST_W'(13);
  localparam logic [BAND_OUT_W-1:0] BandCulled = {BAND_OUT_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_THRESH = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CAM_X = 3'd0,
    CFG_CAM_Y = 3'd1,
    CFG_CAM_Z = 3'd2,
    CFG_HYST  = 3'd3,
    CFG_CULL  = 3'd4
  } cfg_idx_e;

endpackage

### hw/rtl/lbsh_sq_unit.sv
// lbsh_sq_unit: shared squared-difference unit, one axis per enabled cycle
// depends on lbsh_pkg

module lbsh_sq_unit
  import lbsh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] pos_i,
  input  logic signed [COORD_W-1:0] cam_i,
  output logic        [SQ_W-1:0]    sq_o
);

  logic signed [COORD_W:0] diff;
  logic        [COORD_W-1:0] mag;
  logic        [SQ_W-1:0]  sq_q;

  assign diff = $signed({pos_i[COORD_W-1], pos_i}) - $signed({cam_i[COORD_W-1], cam_i});
  assign mag  = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  assign sq_o = sq_q;

endmodule

### hw/rtl/lod_band_select_hysteresis.sv
// lod_band_select_hysteresis: distance based detail band selection with hysteresis
// depends on lbsh_pkg and lbsh_sq_unit
//
// usage: requests enter on the s_axis channel, tuser carries the mode. a threshold
// write or header write gives no result. an evaluate request squares the camera
// offset on one shared squarer (one axis per cycle), checks the cull limit, then
// walks the object's bands, one stored threshold read per band from the threshold
// memory and a margin multiply and a compare per band. the result is registered
// after the square, sum and cull steps, plus the multiply and compare of each band
// searched unless culled or without bands; s_axis_tready is low until then, so a
// new evaluate is not taken before the last one is through.
// results leave through an output register on m_axis; a stalled receiver holds
// the finished result there and the block waits in its last step until the
// register frees. after reset the header store is cleared, one object a cycle,
// with s_axis_tready low until it ends; config writes are taken meanwhile.
// the threshold memory is not cleared and must be written before use.

module lod_band_select_hysteresis
  import lbsh_pkg::*;
#(
  parameter int unsigned NUM_OBJECTS = NumObjectsDef,
  parameter int unsigned MAX_BANDS   = MaxBandsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [DIST_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // object_index, band_index, band_limit_sq, band_total, always_visible,
  // pos_x, pos_y, pos_z, zero pad
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result_index, distance_sq, is_culled, chosen_band, band_changed, zero pad
  output logic [M_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned OBJ_AW   = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int unsigned CUR_W    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned TH_DEPTH = NUM_OBJECTS * MAX_BANDS;
  localparam int unsigned TH_AW    = (TH_DEPTH > 1) ? $clog2(TH_DEPTH) : 1;
  localparam int unsigned CMP_W    = (CUR_W > CNT_W) ? CUR_W : CNT_W;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             av;
    logic [CUR_W-1:0] cur;
  } hdr_t;

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_SQX  = 10'b00_0000_0100,
    S_SQY  = 10'b00_0000_1000,
    S_SQZ  = 10'b00_0001_0000,
    S_SUM  = 10'b00_0010_0000,
    S_CULL = 10'b00_0100_0000,
    S_MUL  = 10'b00_1000_0000,
    S_CMP  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

  // input fields
  logic [OBJ_W-1:0]          in_obj;
  logic [BIDX_W-1:0]         in_band;
  logic [DIST_W-1:0]         in_limit;
  logic [CNT_W-1:0]          in_total;
  logic                      in_av;
  logic signed [COORD_W-1:0] in_px, in_py, in_pz;
  mode_e                     in_mode;

  assign in_obj   = s_axis_tdata[7:0];
  assign in_band  = s_axis_tdata[10:8];
  assign in_limit = s_axis_tdata[53:11];
  assign in_total = s_axis_tdata[57:54];
  assign in_av    = s_axis_tdata[58];
  assign in_px    = s_axis_tdata[78:59];
  assign in_py    = s_axis_tdata[98:79];
  assign in_pz    = s_axis_tdata[118:99];
  assign in_mode  = mode_e'(s_axis_tuser);

  // config registers
  logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [HYST_W-1:0]         hyst_q;
  logic [DIST_W-1:0]         cull_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      hyst_q  <= HystResetVal;
      cull_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CAM_X: cam_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_CAM_Y: cam_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_CAM_Z: cam_z_q <= cfg_data_i[COORD_W-1:0];
        CFG_HYST:  hyst_q  <= cfg_data_i[HYST_W-1:0];
        CFG_CULL:  cull_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e             state_q, state_d;
  logic [OBJ_AW-1:0]  clr_q;
  logic [CNT_W-1:0]   b_q;
  logic               out_valid_q;

  // item and work registers
  logic [OBJ_W-1:0]          obj_q;
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic [DIST_W-1:0]         dist_q;
  logic [DIST_W-1:0]         upper_q, margin_q;
  logic [TH_AW-1:0]          th_addr_q;
  logic                      res_culled_q, res_changed_q;
  logic [CUR_W-1:0]          res_band_q;

  // output registers
  logic [OBJ_W-1:0]      out_idx_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic                  out_culled_q, out_changed_q;
  logic [BAND_OUT_W-1:0] out_band_q;

  // memories
  hdr_t              hdr_mem [NUM_OBJECTS];
  hdr_t              hdr_rdata_q;
  logic [DIST_W-1:0] th_mem [TH_DEPTH];
  logic [DIST_W-1:0] th_rdata_q;

  logic in_acc, obj_ok, band_ok;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign obj_ok  = 32'(in_obj) < NUM_OBJECTS;
  assign band_ok = 32'(in_band) < MAX_BANDS;

  logic [CNT_W-1:0] total_clamped;
  assign total_clamped = (32'(in_total) > MAX_BANDS) ? CNT_W'(MAX_BANDS) : in_total;

  // squarer
  logic                      sq_en;
  logic signed [COORD_W-1:0] sq_pos, sq_cam;
  logic [SQ_W-1:0]           sq;

  always_comb begin
    sq_en  = 1'b1;
    sq_pos = px_q;
    sq_cam = cam_x_q;
    unique case (state_q)
      S_SQY: begin
        sq_pos = py_q;
        sq_cam = cam_y_q;
      end
      S_SQZ: begin
        sq_pos = pz_q;
        sq_cam = cam_z_q;
      end
      S_SQX: sq_en = 1'b1;
      default: sq_en = 1'b0;
    endcase
  end

  lbsh_sq_unit u_sq (
    .clk_i (clk_i),
    .en_i  (sq_en),
    .pos_i (sq_pos),
    .cam_i (sq_cam),
    .sq_o  (sq)
  );

  // band compare
  logic                    culled;
  logic [DIST_W:0]         limit;
  logic                    hit, last;
  logic [CUR_W-1:0]        chosen;
  logic [DIST_W+HYST_W-1:0] prod;

  assign culled = !hdr_rdata_q.av && (cull_q != '0) && (dist_q > cull_q);
  assign prod   = (DIST_W + HYST_W)'(th_rdata_q) * (DIST_W + HYST_W)'(hyst_q);
  assign limit  = {1'b0, upper_q}
                + ((CMP_W'(b_q) < CMP_W'(hdr_rdata_q.cur)) ? {1'b0, margin_q} : '0);
  assign hit    = {1'b0, dist_q} <= limit;
  assign last   = b_q == (hdr_rdata_q.cnt - CNT_W'(1));
  assign chosen = CUR_W'(b_q);

  // header memory write port
  logic              hdr_we;
  logic [OBJ_AW-1:0] hdr_waddr;
  hdr_t              hdr_wdata;

  always_comb begin
    hdr_we    = 1'b0;
    hdr_waddr = OBJ_AW'(obj_q);
    hdr_wdata = hdr_rdata_q;
    hdr_wdata.cur = chosen;
    if (state_q == S_CLR) begin
      hdr_we    = 1'b1;
      hdr_waddr = clr_q;
      hdr_wdata = '0;
    end else if (in_acc && obj_ok && in_mode == MODE_HEADER) begin
      hdr_we        = 1'b1;
      hdr_waddr     = OBJ_AW'(in_obj);
      hdr_wdata.cnt = total_clamped;
      hdr_wdata.av  = in_av;
      hdr_wdata.cur = '0;
    end else if (state_q == S_CMP && (hit || last) && chosen != hdr_rdata_q.cur) begin
      hdr_we = 1'b1;
    end
  end

  logic eval_acc;
  assign eval_acc = in_acc && obj_ok && in_mode == MODE_EVAL;

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (eval_acc) begin
      hdr_rdata_q <= hdr_mem[OBJ_AW'(in_obj)];
    end
  end

  // threshold memory
  logic             th_we, th_re;
  logic [TH_AW-1:0] th_waddr, th_base, th_raddr;

  assign th_we    = in_acc && obj_ok && band_ok && in_mode == MODE_THRESH;
  assign th_waddr = TH_AW'(32'(in_obj) * MAX_BANDS + 32'(in_band));
  assign th_base  = TH_AW'(32'(in_obj) * MAX_BANDS);
  assign th_re    = eval_acc
                 || (state_q == S_MUL && (b_q + CNT_W'(1)) < hdr_rdata_q.cnt);
  assign th_raddr = eval_acc ? th_base : th_addr_q + TH_AW'(1);

  always_ff @(posedge clk_i) begin
    if (th_we) begin
      th_mem[th_waddr] <= in_limit;
    end
    if (th_re) begin
      th_rdata_q <= th_mem[th_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == OBJ_AW'(NUM_OBJECTS - 1)) state_d = S_IDLE;
      S_IDLE: if (eval_acc) state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_SQZ;
      S_SQZ:  state_d = S_SUM;
      S_SUM:  state_d = S_CULL;
      S_CULL: state_d = (culled || hdr_rdata_q.cnt == '0) ? S_DONE : S_MUL;
      S_MUL:  state_d = S_CMP;
      S_CMP:  state_d = (hit || last) ? S_DONE : S_MUL;
      S_DONE: if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + OBJ_AW'(1);
      end
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (eval_acc) begin
          obj_q     <= in_obj;
          px_q      <= in_px;
          py_q      <= in_py;
          pz_q      <= in_pz;
          th_addr_q <= th_base;
        end
      end
      S_SQY: dist_q <= DIST_W'(sq);
      S_SQZ, S_SUM: dist_q <= dist_q + DIST_W'(sq);
      S_CULL: begin
        res_culled_q  <= culled;
        res_changed_q <= 1'b0;
        res_band_q    <= hdr_rdata_q.cur;
        b_q           <= '0;
      end
      S_MUL: begin
        upper_q   <= th_rdata_q;
        margin_q  <= DIST_W'(prod >> HYST_W);
        th_addr_q <= th_addr_q + TH_AW'(1);
      end
      S_CMP: begin
        if (hit || last) begin
          res_band_q    <= chosen;
          res_changed_q <= chosen != hdr_rdata_q.cur;
        end else begin
          b_q <= b_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_idx_q     <= obj_q;
          out_dist_q    <= dist_q;
          out_culled_q  <= res_culled_q;
          out_band_q    <= res_culled_q ? BandCulled : BAND_OUT_W'(res_band_q);
          out_changed_q <= res_changed_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_changed_q, out_band_q, out_culled_q, out_dist_q, out_idx_q};

endmodule
